// File: rtl/lsfb_pkg.sv
package lsfb_pkg;

    localparam int NUM_LEDS = 60;

    localparam int OP_W     = 3;
    localparam int IDX_W    = 6;
    localparam int CH_W     = 8;
    localparam int COL_W    = 3 * CH_W;
    localparam int LVL_W    = 5;
    localparam int WORD_W   = 32;
    localparam int S_DATA_W = 40;

    localparam int ADDR_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int CNT_W  = $clog2(NUM_LEDS + 2);

    localparam logic [IDX_W-1:0]  LED_LIMIT  = IDX_W'(NUM_LEDS);
    localparam logic [ADDR_W:0]   WRAP_LIMIT = (ADDR_W + 1)'(NUM_LEDS);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(NUM_LEDS - 1);
    localparam logic [CNT_W-1:0]  FILL_LAST  = CNT_W'(NUM_LEDS - 1);
    localparam logic [CNT_W-1:0]  SHOW_LAST  = CNT_W'(NUM_LEDS + 1);

    localparam logic [2:0]        LED_HDR    = 3'b111;
    localparam logic [WORD_W-1:0] START_WORD = 32'h0000_0000;
    localparam logic [WORD_W-1:0] END_WORD   = 32'hFFFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_SET_COL = 3'd0,
        OP_SET_LVL = 3'd1,
        OP_ALL_COL = 3'd2,
        OP_ALL_LVL = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_ROTATE  = 3'd5,
        OP_SHOW    = 3'd6
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL_COL,
        ST_FILL_LVL,
        ST_SHOW
    } t_state;

    typedef enum logic [1:0] {
        WK_START = 2'd0,
        WK_LED   = 2'd1,
        WK_END   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [IDX_W-1:0] led_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [LVL_W-1:0] level;
    } t_cmd;

    typedef struct packed {
        logic              col_we;
        logic [ADDR_W-1:0] col_waddr;
        logic [COL_W-1:0]  col_wdata;
        logic              lvl_we;
        logic [ADDR_W-1:0] lvl_waddr;
        logic [LVL_W-1:0]  lvl_wdata;
        logic              clr;
        logic              rd_en;
        logic [ADDR_W-1:0] col_raddr;
        logic [ADDR_W-1:0] lvl_raddr;
    } t_store_req;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_issue;

endpackage

// File: rtl/lsfb_store.sv
module lsfb_store
    import lsfb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_req       i_req,
    output logic [COL_W-1:0] o_col_rd,
    output logic [LVL_W-1:0] o_lvl_rd
);

    logic [COL_W-1:0]    r_col_mem [NUM_LEDS];
    logic [LVL_W-1:0]    r_lvl_mem [NUM_LEDS];
    logic [NUM_LEDS-1:0] r_col_vld;
    logic [NUM_LEDS-1:0] r_lvl_vld;
    logic [COL_W-1:0]    r_col_rd;
    logic [LVL_W-1:0]    r_lvl_rd;
    logic                r_col_rd_vld;
    logic                r_lvl_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.col_we) begin
            r_col_mem[i_req.col_waddr] <= i_req.col_wdata;
        end
        if (i_req.lvl_we) begin
            r_lvl_mem[i_req.lvl_waddr] <= i_req.lvl_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_col_rd     <= r_col_mem[i_req.col_raddr];
            r_lvl_rd     <= r_lvl_mem[i_req.lvl_raddr];
            r_col_rd_vld <= r_col_vld[i_req.col_raddr];
            r_lvl_rd_vld <= r_lvl_vld[i_req.lvl_raddr];
        end
    end

    // An entry that was never written since reset or the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_col_vld <= '0;
            r_lvl_vld <= '0;
        end else begin
            if (i_req.col_we) begin
                r_col_vld[i_req.col_waddr] <= 1'b1;
            end
            if (i_req.lvl_we) begin
                r_lvl_vld[i_req.lvl_waddr] <= 1'b1;
            end
        end
    end

    assign o_col_rd = r_col_rd_vld ? r_col_rd : '0;
    assign o_lvl_rd = r_lvl_rd_vld ? r_lvl_rd : '0;

`ifndef SYNTH
    a_col_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.col_we |-> (i_req.col_waddr <= ADDR_LAST))
        else $error("colour write beyond the last LED");
`endif

endmodule

// File: rtl/lsfb_out.sv
module lsfb_out
    import lsfb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_issue            i_issue,
    input  logic [COL_W-1:0]  i_col_rd,
    input  logic [LVL_W-1:0]  i_lvl_rd,
    output logic              o_b_ready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [WORD_W-1:0] o_m_tdata,
    output logic              o_m_tlast
);

    logic              r_b_valid;
    t_kind             r_b_kind;
    logic              r_c_valid;
    logic [WORD_W-1:0] r_c_word;
    logic              r_c_last;
    logic              c_ready;
    logic [WORD_W-1:0] b_word;

    assign c_ready   = !r_c_valid || i_m_tready;
    assign o_b_ready = !r_b_valid || c_ready;

    always_comb begin
        unique case (r_b_kind)
            WK_START: b_word = START_WORD;
            WK_LED:   b_word = {LED_HDR, i_lvl_rd, i_col_rd[7:0], i_col_rd[15:8],
                                i_col_rd[23:16]};
            WK_END:   b_word = END_WORD;
            default:  b_word = START_WORD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (o_b_ready) begin
                r_b_valid <= i_issue.valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_b_ready && i_issue.valid) begin
            r_b_kind <= i_issue.kind;
        end
        if (c_ready && r_b_valid) begin
            r_c_word <= b_word;
            r_c_last <= (r_b_kind == WK_END);
        end
    end

    assign o_m_tvalid = r_c_valid;
    assign o_m_tdata  = r_c_word;
    assign o_m_tlast  = r_c_last;

`ifndef SYNTH
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == END_WORD))
        else $error("last word of a frame is not the end word");
    a_issue_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !i_m_tready && r_b_valid) |=> r_b_valid)
        else $error("pending word dropped during an output stall");
`endif

endmodule

// File: rtl/lsfb_ctrl.sv
module lsfb_ctrl
    import lsfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_ready,
    input  logic       i_b_ready,
    output t_store_req o_req,
    output t_issue     o_issue
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [COL_W-1:0]  r_colour;
    logic [LVL_W-1:0]  r_level;
    t_opcode           op;
    logic [COL_W-1:0]  cmd_colour;
    logic [ADDR_W-1:0] cmd_led;
    logic [ADDR_W-1:0] show_led;
    logic [CNT_W-1:0]  show_off;
    logic [ADDR_W:0]   cmd_sum;
    logic [ADDR_W:0]   show_sum;
    logic [ADDR_W-1:0] cmd_phys;
    logic [ADDR_W-1:0] show_phys;

    assign op         = t_opcode'(i_cmd.opcode);
    assign cmd_colour = {i_cmd.red, i_cmd.green, i_cmd.blue};
    assign cmd_led    = i_cmd.led_index[ADDR_W-1:0];
    assign show_off   = r_cnt - CNT_W'(1);
    assign show_led   = show_off[ADDR_W-1:0];

    // Rotation is kept as an offset into the colour memory: logical LED k
    // lives at (k + base) mod NUM_LEDS.
    assign cmd_sum   = {1'b0, cmd_led} + {1'b0, r_base};
    assign show_sum  = {1'b0, show_led} + {1'b0, r_base};
    assign cmd_phys  = (cmd_sum >= WRAP_LIMIT) ? ADDR_W'(cmd_sum - WRAP_LIMIT)
                                               : cmd_sum[ADDR_W-1:0];
    assign show_phys = (show_sum >= WRAP_LIMIT) ? ADDR_W'(show_sum - WRAP_LIMIT)
                                                : show_sum[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_colour <= cmd_colour;
            r_level  <= i_cmd.level;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_base  = r_base;
        o_ready = 1'b0;
        o_req   = '0;
        o_issue = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cnt = '0;
                    unique case (op)
                        OP_SET_COL: begin
                            if (i_cmd.led_index < LED_LIMIT) begin
                                o_req.col_we    = 1'b1;
                                o_req.col_waddr = cmd_phys;
                                o_req.col_wdata = cmd_colour;
                            end
                        end
                        OP_SET_LVL: begin
                            if (i_cmd.led_index < LED_LIMIT) begin
                                o_req.lvl_we    = 1'b1;
                                o_req.lvl_waddr = cmd_led;
                                o_req.lvl_wdata = i_cmd.level;
                            end
                        end
                        OP_ALL_COL: n_state = ST_FILL_COL;
                        OP_ALL_LVL: n_state = ST_FILL_LVL;
                        OP_CLEAR:   o_req.clr = 1'b1;
                        OP_ROTATE: begin
                            n_base = (r_base == ADDR_LAST) ? '0 : r_base + ADDR_W'(1);
                        end
                        OP_SHOW:    n_state = ST_SHOW;
                        default: ;
                    endcase
                end
            end
            ST_FILL_COL: begin
                o_req.col_we    = 1'b1;
                o_req.col_waddr = r_cnt[ADDR_W-1:0];
                o_req.col_wdata = r_colour;
                if (r_cnt == FILL_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FILL_LVL: begin
                o_req.lvl_we    = 1'b1;
                o_req.lvl_waddr = r_cnt[ADDR_W-1:0];
                o_req.lvl_wdata = r_level;
                if (r_cnt == FILL_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_SHOW: begin
                if (i_b_ready) begin
                    o_issue.valid = 1'b1;
                    if (r_cnt == '0) begin
                        o_issue.kind = WK_START;
                        n_cnt        = r_cnt + CNT_W'(1);
                    end else if (r_cnt == SHOW_LAST) begin
                        o_issue.kind = WK_END;
                        n_state      = ST_IDLE;
                    end else begin
                        o_issue.kind    = WK_LED;
                        o_req.rd_en     = 1'b1;
                        o_req.col_raddr = show_phys;
                        o_req.lvl_raddr = show_led;
                        n_cnt           = r_cnt + CNT_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= ADDR_LAST)
        else $error("rotation offset out of range");
    a_show_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHOW) |-> (r_cnt <= SHOW_LAST))
        else $error("frame word counter overran");
`endif

endmodule

// File: rtl/led_strip_frame_buffer_core.sv
// Frame buffer for an APA102-style LED strip, one colour and one 5-bit
// brightness per LED.
// Slave channel: each request is one command (set colour, set brightness,
// fill colour, fill brightness, clear, rotate, show). Master channel: the
// 32-bit strip words of a show, the end word marked with tlast; each word is
// meant to be shifted out MSB first on the strip's clock and data lines.
// Set, clear and rotate act as the command is taken. Fill commands write
// every LED in turn, one memory write per cycle. A show walks the store
// through one memory read port, one LED per cycle while the output does not
// stall: NUM_LEDS + 2 words, each passing through the issue register
// and the output register. The next command is taken as soon as the end
// word has been issued, while words still drain to the output.
// Reset clears the valid bits of both memories, so every LED reads as zero
// right after it; no sweep follows. When the receiver holds tready low, the
// output word holds and the show sequencer pauses with it.
module led_strip_frame_buffer_core
    import lsfb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // opcode[2:0], led_index[8:3], red[16:9], green[24:17], blue[32:25],
    // level[37:33], zero fill[39:38]
    input  logic [S_DATA_W-1:0] i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // frame_word[31:0]
    output logic [WORD_W-1:0]   o_m_tdata,
    output logic                o_m_tlast
);

    t_cmd             cmd;
    t_store_req       store_req;
    t_issue           issue;
    logic             b_ready;
    logic [COL_W-1:0] col_rd;
    logic [LVL_W-1:0] lvl_rd;

    assign cmd.opcode    = i_s_tdata[2:0];
    assign cmd.led_index = i_s_tdata[8:3];
    assign cmd.red       = i_s_tdata[16:9];
    assign cmd.green     = i_s_tdata[24:17];
    assign cmd.blue      = i_s_tdata[32:25];
    assign cmd.level     = i_s_tdata[37:33];

    lsfb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_cmd     (cmd),
        .o_ready   (o_s_tready),
        .i_b_ready (b_ready),
        .o_req     (store_req),
        .o_issue   (issue)
    );

    lsfb_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (store_req),
        .o_col_rd (col_rd),
        .o_lvl_rd (lvl_rd)
    );

    lsfb_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (issue),
        .i_col_rd   (col_rd),
        .i_lvl_rd   (lvl_rd),
        .o_b_ready  (b_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
